// ===== rtl/tbc_pkg.sv =====
// Package for the thresholded blob centroid block.
// Holds sizes, gray-level weights and the per-frame sums record.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tbc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int FRAC_BITS  = 4;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int LIT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int SUM_W   = 33;
  localparam int COORD_W = 15;

  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);
  localparam logic [LIT_W-1:0] LIT_LIMIT = LIT_W'(MAX_WIDTH * MAX_HEIGHT);

  // BT.601 luma weights in 14-bit fixed point.
  localparam int WEIGHT_W   = 14;
  localparam int PROD_W     = PIX_W + WEIGHT_W;
  localparam int GRAY_SHIFT = 14;
  localparam logic [WEIGHT_W-1:0] W_RED   = WEIGHT_W'(4899);
  localparam logic [WEIGHT_W-1:0] W_GREEN = WEIGHT_W'(9617);
  localparam logic [WEIGHT_W-1:0] W_BLUE  = WEIGHT_W'(1868);
  localparam logic [PROD_W-1:0]   GRAY_ROUND = PROD_W'(8192);

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(200);

  // Queue of finished frame sums between accumulator and divider.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Divider sizes.
  localparam int DIVD_W = SUM_W + FRAC_BITS;
  localparam int REM_W  = LIT_W;
  localparam int STEP_W = $clog2(COORD_W);

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [LIT_W-1:0] lit_count;
  } frame_sums_t;

endpackage

`default_nettype wire

// ===== rtl/threshold_blob_centroid.sv =====
// Thresholded blob centroid: pixels in at one per cycle, one centroid per frame.
// Path from an accepted frame_end beat to the ports: 2 front stages into the queue,
// 1 load, 15 divide steps (none when no pixel is lit), 1 result register.
// Throughput: one pixel per cycle; the divider takes one frame's sums at a time, so frames
// shorter than a divide, or an unpopped result, fill the 4-slot queue and stall input.
// Reset: synchronous, clears counters, queue and result valid; threshold returns to 200.
`default_nettype none

module threshold_blob_centroid (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [tbc_pkg::PIX_W-1:0]   blue,
  input  wire logic [tbc_pkg::PIX_W-1:0]   green,
  input  wire logic [tbc_pkg::PIX_W-1:0]   red,
  input  wire logic                        row_end,
  input  wire logic                        frame_end,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [tbc_pkg::COORD_W-1:0]      centroid_x,
  output logic [tbc_pkg::COORD_W-1:0]      centroid_y,
  output logic                             light_found,
  input  wire logic                        cfg_we,
  input  wire logic [tbc_pkg::PIX_W-1:0]   cfg_wdata
);
  import tbc_pkg::*;

  // The front end takes a pixel beat every cycle unless full. Each frame leaves one
  // record of sums, which waits in the queue until the divider is free.
  // Frames still in the front pipeline have a queue slot reserved, so the
  // input reports full only when every slot is spoken for.
  logic              accept;
  logic              sums_push;
  frame_sums_t       sums;
  logic [1:0]        frames_in_flight;
  frame_sums_t       q_data;
  logic              q_valid;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   reserved;

  assign reserved = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(frames_in_flight);
  assign full     = reserved >= (QCNT_W + 1)'(QDEPTH);
  assign accept   = push && !full;

  tbc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .blue             (blue),
    .green            (green),
    .red              (red),
    .row_end          (row_end),
    .frame_end        (frame_end),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .sums_push        (sums_push),
    .sums             (sums),
    .frames_in_flight (frames_in_flight)
  );

  // Decouples the pixel rate from the per-frame divide.
  tbc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (sums_push),
    .wdata (sums),
    .pop   (q_pop),
    .rdata (q_data),
    .valid (q_valid),
    .count (q_count)
  );

  // The divider works on the next record while a finished result beat
  // still waits in its output register.
  tbc_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .light_found (light_found)
  );

`ifndef SYNTHESIS
  // A frame with no lit pixel reports zero coordinates.
  a_empty_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !light_found) |-> (centroid_x == '0 && centroid_y == '0))
    else $error("empty frame result has nonzero coordinates");

  // The slot reservation keeps the queue from overflowing.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (sums_push && !q_pop) |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("frame sums pushed into a full queue");

  // The divider only takes a record that is there.
  a_pop_when_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("divider popped an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/tbc_front.sv =====
// Front end: gray conversion, threshold test and per-frame moment sums.
// Depends on tbc_pkg. Pushes one frame_sums_t record per frame.
`default_nettype none

module tbc_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [tbc_pkg::PIX_W-1:0] blue,
  input  wire logic [tbc_pkg::PIX_W-1:0] green,
  input  wire logic [tbc_pkg::PIX_W-1:0] red,
  input  wire logic                      row_end,
  input  wire logic                      frame_end,
  input  wire logic                      cfg_we,
  input  wire logic [tbc_pkg::PIX_W-1:0] cfg_wdata,
  output logic                           sums_push,
  output tbc_pkg::frame_sums_t           sums,
  output logic [1:0]                     frames_in_flight
);
  import tbc_pkg::*;

  logic [PIX_W-1:0] threshold;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic              s1_valid, s1_fe;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [PROD_W-1:0] s1_prod_r, s1_prod_g, s1_prod_b;

  logic              s2_valid, s2_fe, s2_lit;
  logic [COL_W-1:0]  s2_col;
  logic [ROW_W-1:0]  s2_row;

  logic [LIT_W-1:0] lit_count, lit_count_next;
  logic [SUM_W-1:0] sum_of_columns, sum_of_columns_next;
  logic [SUM_W-1:0] sum_of_rows, sum_of_rows_next;

  logic [PROD_W-1:0] gray_sum;
  logic [PIX_W-1:0]  gray;
  logic              lit_add;

  assign gray_sum = s1_prod_r + s1_prod_g + s1_prod_b + GRAY_ROUND;
  assign gray     = gray_sum[PROD_W-1:GRAY_SHIFT];

  assign lit_add = s2_valid && s2_lit && (lit_count < LIT_LIMIT);
  assign lit_count_next      = lit_add ? lit_count + LIT_W'(1) : lit_count;
  assign sum_of_columns_next = lit_add ? sum_of_columns + SUM_W'(s2_col) : sum_of_columns;
  assign sum_of_rows_next    = lit_add ? sum_of_rows + SUM_W'(s2_row) : sum_of_rows;

  // The closing pixel is counted before its frame's record is formed.
  assign sums_push       = s2_valid && s2_fe;
  assign sums.sum_x      = sum_of_columns_next;
  assign sums.sum_y      = sum_of_rows_next;
  assign sums.lit_count  = lit_count_next;

  assign frames_in_flight = {1'b0, s1_valid && s1_fe} + {1'b0, s2_valid && s2_fe};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (accept) begin
        if (frame_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (row_end) begin
          column_count <= '0;
          if (row_count < ROW_LAST) begin
            row_count <= row_count + ROW_W'(1);
          end
        end else if (column_count < COL_LAST) begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fe     <= frame_end;
      s1_col    <= column_count;
      s1_row    <= row_count;
      s1_prod_r <= PROD_W'(red) * PROD_W'(W_RED);
      s1_prod_g <= PROD_W'(green) * PROD_W'(W_GREEN);
      s1_prod_b <= PROD_W'(blue) * PROD_W'(W_BLUE);
    end
    if (s1_valid) begin
      s2_fe  <= s1_fe;
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_lit <= gray > threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_count      <= '0;
      sum_of_columns <= '0;
      sum_of_rows    <= '0;
    end else if (sums_push) begin
      lit_count      <= '0;
      sum_of_columns <= '0;
      sum_of_rows    <= '0;
    end else begin
      lit_count      <= lit_count_next;
      sum_of_columns <= sum_of_columns_next;
      sum_of_rows    <= sum_of_rows_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tbc_queue.sv =====
// Short register queue of frame sums records between front and divider.
// Depends on tbc_pkg for the record type and depth.
`default_nettype none

module tbc_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire tbc_pkg::frame_sums_t      wdata,
  input  wire logic                      pop,
  output tbc_pkg::frame_sums_t           rdata,
  output logic                           valid,
  output logic [tbc_pkg::QCNT_W-1:0]     count
);
  import tbc_pkg::*;

  frame_sums_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic              do_pop;

  assign valid  = count != '0;
  assign rdata  = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tbc_divider.sv =====
// Back end: restoring divider for both centroid coordinates and result register.
// Depends on tbc_pkg. One quotient bit per cycle for x and y in parallel.
`default_nettype none

module tbc_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire tbc_pkg::frame_sums_t        q_data,
  output logic                             q_pop,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [tbc_pkg::COORD_W-1:0]      centroid_x,
  output logic [tbc_pkg::COORD_W-1:0]      centroid_y,
  output logic                             light_found
);
  import tbc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t             state;
  logic [LIT_W-1:0]   divisor;
  logic [REM_W-1:0]   rem_x, rem_y, rem_x_next, rem_y_next;
  logic [COORD_W-1:0] quo_x, quo_y;
  logic [STEP_W-1:0]  step;
  logic               found;
  logic               out_valid;
  logic [REM_W:0]     trial_x, trial_y, diff_x, diff_y;
  logic               ge_x, ge_y;
  logic [DIVD_W-1:0]  dividend_x, dividend_y;
  logic               load_ok;

  assign dividend_x = DIVD_W'(q_data.sum_x) << FRAC_BITS;
  assign dividend_y = DIVD_W'(q_data.sum_y) << FRAC_BITS;

  assign trial_x = {rem_x, quo_x[COORD_W-1]};
  assign trial_y = {rem_y, quo_y[COORD_W-1]};
  assign diff_x  = trial_x - {1'b0, divisor};
  assign diff_y  = trial_y - {1'b0, divisor};
  assign ge_x    = trial_x >= {1'b0, divisor};
  assign ge_y    = trial_y >= {1'b0, divisor};
  assign rem_x_next = ge_x ? diff_x[REM_W-1:0] : trial_x[REM_W-1:0];
  assign rem_y_next = ge_y ? diff_y[REM_W-1:0] : trial_y[REM_W-1:0];

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign empty   = !out_valid;
  assign load_ok = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result beat may replace the one popped in the same cycle.
      if (state == ST_DONE && load_ok) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            divisor <= q_data.lit_count;
            found   <= q_data.lit_count != '0;
            rem_x   <= REM_W'(dividend_x[DIVD_W-1:COORD_W]);
            rem_y   <= REM_W'(dividend_y[DIVD_W-1:COORD_W]);
            step    <= STEP_W'(COORD_W - 1);
            if (q_data.lit_count != '0) begin
              quo_x <= dividend_x[COORD_W-1:0];
              quo_y <= dividend_y[COORD_W-1:0];
              state <= ST_DIV;
            end else begin
              quo_x <= '0;
              quo_y <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          quo_x <= {quo_x[COORD_W-2:0], ge_x};
          quo_y <= {quo_y[COORD_W-2:0], ge_y};
          step  <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_ok) begin
            centroid_x  <= quo_x;
            centroid_y  <= quo_y;
            light_found <= found;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
